FILE: rtl/clcs_pkg.sv
// types, codes and command tables shared by the lcd command sequencer
`timescale 1ns / 1ps
package clcs_pkg;

	localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
	localparam logic [1:0] OP_SET_CURSOR = 2'd1;
	localparam logic [1:0] OP_CLEAR      = 2'd2;
	localparam logic [1:0] OP_INIT       = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;

	localparam logic [7:0] CMD_SOFT_RESET = 8'h30;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_SET_ADDR   = 8'h80;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA    = 1'b1;

	localparam int INIT_LEN = 7;
	localparam int STEP_W   = $clog2(INIT_LEN);
	localparam int LINE_W   = 2;

	// one request as the back end carries it out
	typedef struct packed {
		logic       is_init;
		logic       lead_clr;
		logic [7:0] main_byte;
		logic       main_rs;
		logic       trail_clr;
	} job_t;

	function automatic logic [7:0] row_base(input logic [LINE_W-1:0] ln);
		logic [7:0] b;
		case (ln)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
		logic [7:0] b;
		case (step)
			3'd0, 3'd1, 3'd2: b = CMD_SOFT_RESET;
			3'd3:             b = CMD_FUNC_SET;
			3'd4:             b = CMD_ENTRY_MODE;
			3'd5:             b = CMD_DISPLAY_ON;
			default:          b = CMD_CLEAR;
		endcase
		return b;
	endfunction

	// line modulo (last_line + 1) for last_line 1 to 3, else ln[1:0]; base 4 digits sum to the same residue mod 3
	function automatic logic [LINE_W-1:0] line_wrap(input logic [7:0] ln,
			input logic [LINE_W-1:0] last_line);
		logic [3:0]        dsum;
		logic [2:0]        fold1;
		logic [2:0]        fold2;
		logic [LINE_W-1:0] r;
		dsum  = {2'b00, ln[1:0]} + {2'b00, ln[3:2]} + {2'b00, ln[5:4]} + {2'b00, ln[7:6]};
		fold1 = {1'b0, dsum[3:2]} + {1'b0, dsum[1:0]};
		fold2 = {2'b00, fold1[2]} + {1'b0, fold1[1:0]};
		case (last_line)
			2'd1:    r = {1'b0, ln[0]};
			2'd2:    r = (fold2 >= 3'd3) ? 2'(fold2 - 3'd3) : fold2[1:0];
			default: r = ln[1:0];
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/clcs_req_if.sv
// request channel: operation and its arguments
`timescale 1ns / 1ps
interface clcs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] char_code;
	logic [7:0] line;
	logic [7:0] column;

	modport source (output valid, operation, char_code, line, column, input ready);
	modport sink (input valid, operation, char_code, line, column, output ready);
endinterface

FILE: rtl/clcs_wr_if.sv
// bus write channel: one lcd byte write per transaction
`timescale 1ns / 1ps
interface clcs_wr_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       register_select;
	logic       last;

	modport source (output valid, bus_byte, register_select, last, input ready);
	modport sink (input valid, bus_byte, register_select, last, output ready);
endinterface

FILE: rtl/clcs_front.sv
// front end: decodes requests, tracks the cursor line, builds jobs
`timescale 1ns / 1ps
module clcs_front
	import clcs_pkg::*;
#(
	parameter int LAST_LINE = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	clcs_req_if.sink     req,
	input  logic         q_full,
	output logic         push,
	output job_t         push_job
);

	logic [LINE_W-1:0] cur_line_q;
	logic [7:0]        tgt_line;
	logic [7:0]        tgt_col;
	logic              is_cursor;
	logic [LINE_W-1:0] wrapped;
	logic [7:0]        addr;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		tgt_line  = 8'd0;
		tgt_col   = 8'd0;
		is_cursor = 1'b0;
		push_job  = '0;
		unique case (req.operation)
			OP_WRITE_CHAR: begin
				if (req.char_code == CHAR_NEWLINE) begin
					tgt_line  = 8'({1'b0, cur_line_q} + 3'd1);
					is_cursor = 1'b1;
				end else if (req.char_code == CHAR_RETURN) begin
					tgt_line  = 8'(cur_line_q);
					is_cursor = 1'b1;
				end else begin
					push_job.main_byte = req.char_code;
					push_job.main_rs   = RS_DATA;
				end
			end
			OP_SET_CURSOR: begin
				tgt_line  = req.line;
				tgt_col   = req.column;
				is_cursor = 1'b1;
			end
			OP_CLEAR: begin
				is_cursor          = 1'b1;
				push_job.trail_clr = 1'b1;
			end
			OP_INIT: begin
				push_job.is_init = 1'b1;
			end
			default: ;
		endcase
		wrapped = line_wrap(tgt_line, LINE_W'(LAST_LINE));
		addr    = row_base(wrapped) + tgt_col;
		if (is_cursor) begin
			push_job.lead_clr  = tgt_line > 8'(LAST_LINE);
			push_job.main_byte = CMD_SET_ADDR | addr;
			push_job.main_rs   = RS_COMMAND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q <= '0;
		end else if (push && is_cursor) begin
			cur_line_q <= wrapped;
		end
	end

endmodule

FILE: rtl/clcs_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps
module clcs_queue
	import clcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic avail,
	output job_t head
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W+1)'(DEPTH);
	assign avail = count_q != '0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

FILE: rtl/clcs_back.sv
// back end: steps through the writes of each job into the output register
`timescale 1ns / 1ps
module clcs_back
	import clcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_avail,
	input  job_t     q_head,
	output logic     pop,
	clcs_wr_if.source wr
);

	localparam logic [1:0] PH_LEAD  = 2'd0;
	localparam logic [1:0] PH_MAIN  = 2'd1;
	localparam logic [1:0] PH_TRAIL = 2'd2;
	localparam logic [1:0] PH_INIT  = 2'd3;

	logic              busy_q;
	job_t              job_q;
	logic [1:0]        phase_q;
	logic [STEP_W-1:0] step_q;
	logic              ovalid_q;
	logic [7:0]        obyte_q;
	logic              ors_q;
	logic              olast_q;

	logic       emit;
	logic       load;
	logic [7:0] cur_byte;
	logic       cur_rs;
	logic       cur_last;

	always_comb begin
		cur_byte = CMD_CLEAR;
		cur_rs   = RS_COMMAND;
		cur_last = 1'b0;
		unique case (phase_q)
			PH_LEAD: ;
			PH_MAIN: begin
				cur_byte = job_q.main_byte;
				cur_rs   = job_q.main_rs;
				cur_last = !job_q.trail_clr;
			end
			PH_TRAIL: cur_last = 1'b1;
			PH_INIT: begin
				cur_byte = init_byte(step_q);
				cur_last = step_q == STEP_W'(INIT_LEN - 1);
			end
			default: ;
		endcase
	end

	assign emit = busy_q && (!ovalid_q || wr.ready);
	assign load = !busy_q || (emit && cur_last);
	assign pop  = load && q_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_LEAD;
			step_q  <= '0;
		end else if (load) begin
			busy_q <= q_avail;
			step_q <= '0;
			if (q_head.is_init) begin
				phase_q <= PH_INIT;
			end else if (q_head.lead_clr) begin
				phase_q <= PH_LEAD;
			end else begin
				phase_q <= PH_MAIN;
			end
		end else if (emit) begin
			unique case (phase_q)
				PH_LEAD:  phase_q <= PH_MAIN;
				PH_MAIN:  phase_q <= PH_TRAIL;
				PH_TRAIL: phase_q <= PH_TRAIL;
				PH_INIT:  step_q  <= step_q + 1'b1;
				default:  phase_q <= PH_LEAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			obyte_q <= cur_byte;
			ors_q   <= cur_rs;
			olast_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (wr.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign wr.valid           = ovalid_q;
	assign wr.bus_byte        = obyte_q;
	assign wr.register_select = ors_q;
	assign wr.last            = olast_q;

endmodule

FILE: rtl/char_lcd_command_sequencer_top.sv
// top level of the character lcd command sequencer
`timescale 1ns / 1ps
// Turns requests (write character, set cursor, clear, initialize) into the byte writes of an
// 8-bit character lcd bus, each tagged with its register select and a last flag on the final
// write of the request. The front end takes a request whenever the two-entry job queue has
// room, so requests can arrive back to back; the back end emits one bus write per cycle from
// its output register while the bus is ready and jobs wait. A request takes 1 to 7 bus writes
// (1 for a data byte, 1 or 2 for cursor moves, 2 for clear, 7 for initialize), and that write
// rate sets the sustained request rate. Newline and carriage return use the cursor line kept in
// the front end. Enable pulse timing and command delays are up to the bus driver downstream.
module char_lcd_command_sequencer_top
	import clcs_pkg::*;
#(
	parameter int LAST_LINE = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	clcs_req_if.sink  req,
	clcs_wr_if.source wr
);

	logic push;
	job_t push_job;
	logic pop;
	logic q_full;
	logic q_avail;
	job_t q_head;

	clcs_front #(
		.LAST_LINE(LAST_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	clcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.avail    (q_avail),
		.head     (q_head)
	);

	clcs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_head  (q_head),
		.pop     (pop),
		.wr      (wr)
	);

endmodule
